// ===== rtl/triple_tea_block_cipher_defines.svh =====
// assertion macros for the triple tea block cipher
// used by the modules that carry assertions, no other dependencies
`ifndef TRIPLE_TEA_BLOCK_CIPHER_DEFINES_SVH
`define TRIPLE_TEA_BLOCK_CIPHER_DEFINES_SVH
`ifndef SYNTHESIS
`define TTEA_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ttea implication check failed");
`define TTEA_ASSERT_NXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ttea next-cycle check failed");
`else
`define TTEA_ASSERT_IMP(lbl, clk, rst, pre, post)
`define TTEA_ASSERT_NXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== rtl/ttea_pkg.sv =====
// shared types, constants and round helpers for the triple tea block cipher
// no dependencies
package ttea_pkg;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;
  localparam int unsigned ROUNDS = 32;
  localparam int unsigned LAYERS = 3;
  localparam int unsigned STAGES = LAYERS * ROUNDS * 2;
  localparam int unsigned ADDR_W = 6;

  typedef enum logic [2:0] {
    REG_L0_W01 = 3'd0,
    REG_L0_W23 = 3'd1,
    REG_L1_W01 = 3'd2,
    REG_L1_W23 = 3'd3,
    REG_L2_W01 = 3'd4,
    REG_L2_W23 = 3'd5
  } reg_idx_t;

  typedef logic [3:0][31:0] key_set_t;
  typedef key_set_t [LAYERS-1:0] key_bank_t;

  typedef struct packed {
    logic        func;
    logic [31:0] a;
    logic [31:0] b;
  } blk_t;

  function automatic logic [31:0] mix(input logic [31:0] x);
    return (x << 4) ^ (x >> 5);
  endfunction

  // round sum after n steps, mod 2^32
  function automatic logic [31:0] sum_at(input logic [5:0] n);
    return DELTA * {26'd0, n};
  endfunction

endpackage

// ===== rtl/ttea_key_regs.sv =====
// apb register file holding the six 64-bit layer key registers
// depends on ttea_pkg and triple_tea_block_cipher_defines.svh
`include "triple_tea_block_cipher_defines.svh"

module ttea_key_regs
  import ttea_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  output key_bank_t         keys
);

  logic [63:0] l0w01, l0w23, l1w01, l1w23, l2w01, l2w23;
  logic        wr_en;
  reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      l0w01 <= '0;
      l0w23 <= '0;
      l1w01 <= '0;
      l1w23 <= '0;
      l2w01 <= '0;
      l2w23 <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_L0_W01: l0w01 <= pwdata;
        REG_L0_W23: l0w23 <= pwdata;
        REG_L1_W01: l1w01 <= pwdata;
        REG_L1_W23: l1w23 <= pwdata;
        REG_L2_W01: l2w01 <= pwdata;
        REG_L2_W23: l2w23 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_L0_W01: prdata = l0w01;
      REG_L0_W23: prdata = l0w23;
      REG_L1_W01: prdata = l1w01;
      REG_L1_W23: prdata = l1w23;
      REG_L2_W01: prdata = l2w01;
      REG_L2_W23: prdata = l2w23;
      default:    prdata = '0;
    endcase
  end

  // word 0 sits in the upper half of the words01 register
  assign keys[0] = {l0w23[31:0], l0w23[63:32], l0w01[31:0], l0w01[63:32]};
  assign keys[1] = {l1w23[31:0], l1w23[63:32], l1w01[31:0], l1w01[63:32]};
  assign keys[2] = {l2w23[31:0], l2w23[63:32], l2w01[31:0], l2w01[63:32]};

  `TTEA_ASSERT_NXT(a_wr_l0, clk, rst, wr_en && idx == REG_L0_W01, l0w01 == $past(pwdata))
  `TTEA_ASSERT_NXT(a_hold_l2, clk, rst, !wr_en, $stable(l2w23) && $stable(l1w01))

endmodule

// ===== rtl/ttea_stage.sv =====
// one registered half-round of a tea layer, both directions
// depends on ttea_pkg
module ttea_stage
  import ttea_pkg::*;
#(
  parameter int unsigned ROUND = 0,
  parameter bit          HALF  = 1'b0
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  blk_t     in_blk,
  input  key_set_t enc_key,
  input  key_set_t dec_key,
  output logic     out_valid,
  output blk_t     out_blk
);

  localparam logic [31:0] ENC_SUM = sum_at(HALF ? 6'(ROUND + 1) : 6'(ROUND));
  localparam logic [31:0] DEC_SUM = sum_at(HALF ? 6'(ROUNDS - 1 - ROUND)
                                                : 6'(ROUNDS - ROUND));
  localparam logic [1:0]  ENC_IDX = HALF ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam logic [1:0]  DEC_IDX = HALF ? DEC_SUM[1:0] : DEC_SUM[12:11];

  logic        dst_b;
  logic [31:0] src, dst, s, k, term, upd;

  always_comb begin
    dst_b = in_blk.func ^ HALF;
    src   = dst_b ? in_blk.a : in_blk.b;
    dst   = dst_b ? in_blk.b : in_blk.a;
    s     = in_blk.func ? DEC_SUM : ENC_SUM;
    k     = in_blk.func ? dec_key[DEC_IDX] : enc_key[ENC_IDX];
    term  = (src ^ s) + k + mix(src);
    upd   = in_blk.func ? dst - term : dst + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_blk.func <= in_blk.func;
    out_blk.a    <= dst_b ? in_blk.a : upd;
    out_blk.b    <= dst_b ? upd : in_blk.b;
  end

endmodule

// ===== rtl/triple_tea_block_cipher.sv =====
// top level of the triple tea block cipher: key registers and round pipeline
// depends on ttea_pkg, ttea_key_regs, ttea_stage and the defines header
//
//   channel   ports                                    handshake
//   request   start, busy, func, block                 start && !busy
//   result    done, result_block                       done, one cycle
//   config    psel penable pwrite paddr pwdata prdata  apb, pready high
//
// one request per cycle, accepted whenever start is high
// the pipeline holds 192 half-round stages, one per register stage
// busy stays low: every stage advances each cycle
// reset clears the stage valid bits and the key registers
// results cannot be held off, none are dropped or repeated
`include "triple_tea_block_cipher_defines.svh"

module triple_tea_block_cipher
  import ttea_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [63:0]       block,
  output logic              done,
  output logic [63:0]       result_block,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  key_bank_t keys;
  logic      valid [STAGES+1];
  blk_t      blk   [STAGES+1];

  ttea_key_regs u_keys (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .keys    (keys)
  );

  assign busy       = 1'b0;
  assign valid[0]   = start && !busy;
  assign blk[0]     = '{func: func, a: block[63:32], b: block[31:0]};

  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam int unsigned LAYER = j / (2 * ROUNDS);
    ttea_stage #(
      .ROUND ((j / 2) % ROUNDS),
      .HALF  (1'(j % 2))
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[j]),
      .in_blk    (blk[j]),
      .enc_key   (keys[LAYER]),
      .dec_key   (keys[LAYERS - 1 - LAYER]),
      .out_valid (valid[j+1]),
      .out_blk   (blk[j+1])
    );
  end

  assign done         = valid[STAGES];
  assign result_block = {blk[STAGES].a, blk[STAGES].b};

  `TTEA_ASSERT_NXT(a_enter, clk, rst, start, valid[1])
  `TTEA_ASSERT_IMP(a_done_src, clk, rst, done, $past(start && !rst, STAGES))

endmodule
